// ===== design/ircap_pkg.sv =====
// Shared types, constants and codes for the IR edge duration capture unit.
package ircap_pkg;

	localparam int unsigned US_PER_SECOND = 1000000;
	localparam int unsigned US_PER_MS     = US_PER_SECOND / 1000;

	localparam int unsigned KIND_W     = 2;
	localparam int unsigned TIMEOUT_W  = 10;
	localparam int unsigned ADJUST_W   = 12;
	localparam int unsigned ELAPSED_W  = 20;
	localparam int unsigned COUNT_W    = 8;
	localparam int unsigned INDEX_W    = 7;
	localparam int unsigned INTERVAL_W = 22;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;

	localparam int unsigned MAX_ENTRIES_DEFAULT = 128;
	localparam int unsigned TIMEOUT_MS_RESET    = 10;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENABLE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DISABLE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_ADJUST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPACE_ADJUST = 2'd2;

	typedef enum logic [1:0] {
		MODE_DISABLED  = 2'd0,
		MODE_ARMED     = 2'd1,
		MODE_RECEIVING = 2'd2,
		MODE_FINISHED  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              line_level;
	} item_t;

	typedef struct packed {
		logic signed [INTERVAL_W-1:0] interval_us;
		logic                         was_pulse;
		logic [INDEX_W-1:0]           entry_index;
		logic                         last;
	} result_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== design/ircap_in_if.sv =====
// Input channel: tick samples and enable/disable commands.
interface ircap_in_if
	import ircap_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic              line_level;

	modport source (output valid, output kind, output line_level, input ready);
	modport sink (input valid, input kind, input line_level, output ready);
endinterface

// ===== design/ircap_out_if.sv =====
// Output channel: captured interval entries.
interface ircap_out_if
	import ircap_pkg::*;
();
	logic                         valid;
	logic                         ready;
	logic signed [INTERVAL_W-1:0] interval_us;
	logic                         was_pulse;
	logic [INDEX_W-1:0]           entry_index;
	logic                         last;

	modport source (output valid, output interval_us, output was_pulse,
		output entry_index, output last, input ready);
	modport sink (input valid, input interval_us, input was_pulse,
		input entry_index, input last, output ready);
endinterface

// ===== design/ircap_in_stage.sv =====
// Input register stage holding one accepted item.
module ircap_in_stage
	import ircap_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  space,
	output logic  fire,
	output item_t item_s1
);
	logic valid_s1;

	assign fire     = valid_s1 && space;
	assign in_ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end
endmodule

// ===== design/ircap_core.sv =====
// Capture state, configuration registers and per-item result logic.
module ircap_core
	import ircap_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    fire,
	input  item_t   item,
	output logic    res_valid,
	output result_t res
);
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_ENTRIES);
	localparam logic [ELAPSED_W-1:0] TIMEOUT_US_RESET =
		ELAPSED_W'(TIMEOUT_MS_RESET * US_PER_MS);

	logic [ELAPSED_W-1:0]       timeout_us_q;
	logic signed [ADJUST_W-1:0] pulse_adjust_q;
	logic signed [ADJUST_W-1:0] space_adjust_q;

	mode_t                mode_q, mode_d;
	logic                 prev_q, prev_d;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
	logic [COUNT_W-1:0]   count_q, count_d;

	logic [ELAPSED_W-1:0]       elapsed_inc;
	logic [COUNT_W-1:0]         count_inc;
	logic signed [ADJUST_W-1:0] adj;

	// timeout kept in microseconds, scaled once at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_us_q   <= TIMEOUT_US_RESET;
			pulse_adjust_q <= '0;
			space_adjust_q <= '0;
		end else if (cfg.we) begin
			case (cfg.index)
				REG_TIMEOUT_MS: begin
					timeout_us_q <= ELAPSED_W'(cfg.data[TIMEOUT_W-1:0])
						* ELAPSED_W'(US_PER_MS);
				end
				REG_PULSE_ADJUST: pulse_adjust_q <= cfg.data[ADJUST_W-1:0];
				REG_SPACE_ADJUST: space_adjust_q <= cfg.data[ADJUST_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_DISABLED;
			prev_q    <= 1'b0;
			elapsed_q <= '0;
			count_q   <= '0;
		end else begin
			mode_q    <= mode_d;
			prev_q    <= prev_d;
			elapsed_q <= elapsed_d;
			count_q   <= count_d;
		end
	end

	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign count_inc   = count_q + 1'b1;
	assign adj         = prev_q ? pulse_adjust_q : space_adjust_q;

	always_comb begin
		mode_d    = mode_q;
		prev_d    = prev_q;
		elapsed_d = elapsed_q;
		count_d   = count_q;
		res_valid = 1'b0;
		res       = '0;
		if (fire) begin
			case (item.kind)
				KIND_ENABLE: begin
					if (mode_q inside {MODE_DISABLED, MODE_FINISHED}) begin
						mode_d = MODE_ARMED;
					end
				end
				KIND_DISABLE: mode_d = MODE_DISABLED;
				KIND_TICK: begin
					case (mode_q)
						MODE_ARMED: begin
							if (item.line_level) begin
								prev_d    = 1'b1;
								elapsed_d = '0;
								count_d   = '0;
								mode_d    = MODE_RECEIVING;
							end
						end
						MODE_RECEIVING: begin
							res.was_pulse   = prev_q;
							res.entry_index = count_q[INDEX_W-1:0];
							if (item.line_level != prev_q) begin
								// edge wins over a timeout on the same tick
								res_valid       = 1'b1;
								res.interval_us = $signed({2'b00, elapsed_inc})
									+ INTERVAL_W'(adj);
								res.last        = (count_inc >= COUNT_LIMIT);
								count_d         = count_inc;
								prev_d          = item.line_level;
								elapsed_d       = '0;
								if (count_inc >= COUNT_LIMIT) begin
									mode_d = MODE_FINISHED;
								end
							end else if (elapsed_inc >= timeout_us_q) begin
								res_valid       = 1'b1;
								res.interval_us = $signed({2'b00, elapsed_inc});
								res.last        = 1'b1;
								count_d         = count_inc;
								elapsed_d       = elapsed_inc;
								mode_d          = MODE_FINISHED;
							end else begin
								elapsed_d = elapsed_inc;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== design/ircap_out_fifo.sv =====
// Two-entry result queue between the core and the output channel.
module ircap_out_fifo
	import ircap_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);
	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign space     = !count_q[1];
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ===== design/ir_edge_duration_capture_unit.sv =====
// Top level of the IR edge duration capture unit.
// Takes one item (a microsecond tick with the sampled line level, an enable or a
// disable) per clock cycle and answers each with zero or one interval entry. An
// item passes an input register, is evaluated combinationally against the
// capture state, and its entry lands in a two-entry output queue, which
// presents it at the output. The queue lets new items be taken while an entry
// waits at the output; input stalls only when the queue is full. Configuration
// writes take effect on the next cycle; the timeout is scaled to microseconds
// when written.
module ir_edge_duration_capture_unit
	import ircap_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ircap_in_if.sink              sample,
	ircap_out_if.source           entry
);
	item_t   in_item;
	item_t   item_s1;
	cfg_wr_t cfg;
	logic    fire;
	logic    space;
	logic    res_valid;
	result_t res;
	result_t out_data;

	assign in_item.kind       = sample.kind;
	assign in_item.line_level = sample.line_level;
	assign cfg.we             = cfg_we;
	assign cfg.index          = cfg_index;
	assign cfg.data           = cfg_data;

	ircap_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.in_item  (in_item),
		.space    (space),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	ircap_core #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ircap_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (entry.valid),
		.out_ready (entry.ready),
		.out_data  (out_data)
	);

	assign entry.interval_us = out_data.interval_us;
	assign entry.was_pulse   = out_data.was_pulse;
	assign entry.entry_index = out_data.entry_index;
	assign entry.last        = out_data.last;
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the IR edge duration capture unit.
`timescale 1ns / 100ps

module testbench;
	import ircap_pkg::*;

	localparam int unsigned CAPACITY    = MAX_ENTRIES_DEFAULT;
	localparam int unsigned PHASE_ITEMS = 100;
	localparam int unsigned SETTLE      = 6;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned MAX_TMO_RUNS = 1;
	localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic  in_valid  = 1'b0;
	item_t in_item   = '0;
	logic  out_ready = 1'b0;

	ircap_in_if  sample_if ();
	ircap_out_if entry_if ();

	assign sample_if.valid      = in_valid;
	assign sample_if.kind       = in_item.kind;
	assign sample_if.line_level = in_item.line_level;
	assign entry_if.ready       = out_ready;

	ir_edge_duration_capture_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_if.sink),
		.entry     (entry_if.source)
	);

	// stimulus and predicted entries
	item_t   item_q[$];
	result_t entry_q[$];
	int      err_count  = 0;
	int      stim_count = 0;

	int unsigned tx_idle = 31;
	int unsigned rx_idle = 31;

	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	// predictor copy of configuration and capture state
	logic [TIMEOUT_W-1:0]       tmo_ms = TIMEOUT_W'(TIMEOUT_MS_RESET);
	logic signed [ADJUST_W-1:0] p_adj  = '0;
	logic signed [ADJUST_W-1:0] s_adj  = '0;
	mode_t                      cap_mode = MODE_DISABLED;
	logic                       prev_lvl = 1'b0;
	logic [ELAPSED_W-1:0]       elapsed  = '0;
	logic [COUNT_W-1:0]         count    = '0;

	task automatic advance_capture(input item_t it);
		result_t                      r;
		logic signed [INTERVAL_W-1:0] adj;
		case (it.kind)
			KIND_ENABLE: begin
				if (cap_mode == MODE_DISABLED || cap_mode == MODE_FINISHED)
					cap_mode = MODE_ARMED;
			end
			KIND_DISABLE: cap_mode = MODE_DISABLED;
			KIND_TICK: begin
				if (cap_mode == MODE_ARMED) begin
					if (it.line_level) begin
						prev_lvl = 1'b1;
						elapsed  = '0;
						count    = '0;
						cap_mode = MODE_RECEIVING;
					end
				end else if (cap_mode == MODE_RECEIVING) begin
					if (elapsed != ELAPSED_MAX)
						elapsed = elapsed + 1'b1;
					if (it.line_level != prev_lvl) begin
						// edge wins over a timeout on the same tick
						adj           = prev_lvl ? p_adj : s_adj;
						r.interval_us = $signed({2'b00, elapsed}) + adj;
						r.was_pulse   = prev_lvl;
						r.entry_index = count[INDEX_W-1:0];
						count         = count + 1'b1;
						r.last        = (count >= CAPACITY);
						if (r.last)
							cap_mode = MODE_FINISHED;
						prev_lvl = it.line_level;
						elapsed  = '0;
						entry_q.push_back(r);
					end else if (elapsed >= tmo_ms * US_PER_MS) begin
						r.interval_us = $signed({2'b00, elapsed});
						r.was_pulse   = prev_lvl;
						r.entry_index = count[INDEX_W-1:0];
						count         = count + 1'b1;
						r.last        = 1'b1;
						cap_mode      = MODE_FINISHED;
						entry_q.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// sender: one item per transfer, random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && sample_if.ready)
				advance_capture(in_item);
			if (!in_valid || sample_if.ready) begin
				if (item_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
					in_item  <= item_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, armed once
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// receiver: check every entry transfer against the oldest prediction
	always @(posedge clk) begin : mon
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (entry_if.valid && out_ready) begin
				if (entry_q.size() == 0) begin
					$error("entry with none predicted: interval_us %0d",
						entry_if.interval_us);
					err_count++;
				end else begin
					want = entry_q.pop_front();
					if (entry_if.interval_us !== want.interval_us) begin
						$error("interval_us: expected %0d, got %0d",
							want.interval_us, entry_if.interval_us);
						err_count++;
					end
					if (entry_if.was_pulse !== want.was_pulse) begin
						$error("was_pulse: expected %0d, got %0d",
							want.was_pulse, entry_if.was_pulse);
						err_count++;
					end
					if (entry_if.entry_index !== want.entry_index) begin
						$error("entry_index: expected %0d, got %0d",
							want.entry_index, entry_if.entry_index);
						err_count++;
					end
					if (entry_if.last !== want.last) begin
						$error("last: expected %0d, got %0d",
							want.last, entry_if.last);
						err_count++;
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic push_item(input logic [KIND_W-1:0] k, input logic lvl,
		input bit counted = 1'b1);
		item_q.push_back(item_t'{kind: k, line_level: lvl});
		if (counted)
			stim_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_TIMEOUT_MS:   tmo_ms = val[TIMEOUT_W-1:0];
			REG_PULSE_ADJUST: p_adj  = val;
			REG_SPACE_ADJUST: s_adj  = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until all items are transferred and all entries have arrived
	task automatic drain();
		do
			@(posedge clk);
		while (item_q.size() != 0 || in_valid || entry_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic gen_noise();
		repeat ($urandom_range(1, 5))
			push_item(KIND_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
	endtask

	// one capture: arm, alternating runs, then disable, timeout or carry on
	task automatic gen_capture(input bit full_run, inout int tmo_runs);
		int unsigned n_edges;
		int unsigned len;
		int unsigned pick;
		logic        lvl;
		if (full_run || $urandom_range(15) == 0)
			n_edges = CAPACITY + $urandom_range(0, 2);
		else
			n_edges = $urandom_range(1, 20);
		push_item(KIND_ENABLE, 1'($urandom_range(0, 1)));
		if ($urandom_range(3) == 0)
			push_item(KIND_ENABLE, 1'($urandom_range(0, 1)));
		repeat ($urandom_range(0, 2))
			push_item(KIND_TICK, 1'b0);
		lvl = 1'b1;
		for (int e = 0; e < n_edges; e++) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 5);
			repeat (len)
				push_item(KIND_TICK, lvl);
			if ($urandom_range(40) == 0)
				push_item($urandom_range(0, 1) ? KIND_ENABLE : KIND_UNUSED,
					1'($urandom_range(0, 1)));
			lvl = ~lvl;
		end
		pick = $urandom_range(9);
		if (tmo_ms <= 1 && tmo_runs < MAX_TMO_RUNS) begin
			// a run of exactly the timeout length ends on an edge, longer runs time out
			len = tmo_ms * US_PER_MS + $urandom_range(0, 3);
			repeat (len)
				push_item(KIND_TICK, lvl);
			push_item(KIND_TICK, ~lvl);
			tmo_runs++;
		end else if (pick < 8) begin
			push_item(KIND_DISABLE, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_phase(input int unsigned tmo, input logic [CFG_DATA_W-1:0] padj,
		input logic [CFG_DATA_W-1:0] sadj, input int unsigned idle, input bit full_run,
		input bit with_hold);
		int tmo_runs;
		tmo_runs = 0;
		drain();
		write_reg(REG_TIMEOUT_MS, {2'($urandom_range(0, 3)), TIMEOUT_W'(tmo)});
		write_reg(REG_PULSE_ADJUST, padj);
		write_reg(REG_SPACE_ADJUST, sadj);
		repeat (2) @(posedge clk);
		tx_idle    = idle;
		rx_idle    = idle;
		stim_count = 0;
		if (full_run)
			gen_capture(1'b1, tmo_runs);
		while (stim_count < PHASE_ITEMS) begin
			if ($urandom_range(4) == 0)
				gen_noise();
			else
				gen_capture(1'b0, tmo_runs);
		end
		if (with_hold)
			hold_req = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset configuration: ignored items, start, edges, rearm
		push_item(KIND_TICK, 1'b1);
		push_item(KIND_UNUSED, 1'b1);
		push_item(KIND_ENABLE, 1'b0);
		push_item(KIND_TICK, 1'b0);
		push_item(KIND_TICK, 1'b1);
		push_item(KIND_ENABLE, 1'b1);
		push_item(KIND_TICK, 1'b1);
		push_item(KIND_TICK, 1'b1);
		push_item(KIND_TICK, 1'b0);
		push_item(KIND_TICK, 1'b0);
		push_item(KIND_TICK, 1'b1);
		push_item(KIND_DISABLE, 1'b0);
		push_item(KIND_TICK, 1'b0);
		push_item(KIND_ENABLE, 1'b0);
		push_item(KIND_TICK, 1'b1);
		push_item(KIND_TICK, 1'b0);
		push_item(KIND_DISABLE, 1'b1);
		drain();

		// zero timeout: edge beats timeout, then timeout on the first quiet tick
		write_reg(REG_TIMEOUT_MS, '0);
		write_reg(REG_PULSE_ADJUST, 12'h800);
		write_reg(REG_SPACE_ADJUST, 12'h7FF);
		repeat (2) @(posedge clk);
		push_item(KIND_ENABLE, 1'b0);
		push_item(KIND_TICK, 1'b1);
		push_item(KIND_TICK, 1'b0);
		push_item(KIND_TICK, 1'b1);
		push_item(KIND_TICK, 1'b1);
		push_item(KIND_TICK, 1'b0);
		push_item(KIND_ENABLE, 1'b1);
		push_item(KIND_TICK, 1'b1);
		push_item(KIND_TICK, 1'b1);

		run_phase(1, CFG_DATA_W'($urandom_range(0, 4095)),
			CFG_DATA_W'($urandom_range(0, 4095)), 31, 1'b0, 1'b1);
		run_phase(1000, 12'h800, 12'h7FF, 0, 1'b1, 1'b0);
		run_phase(2, 12'h7FF, 12'h800, 31, 1'b0, 1'b0);
		run_phase(0, '0, CFG_DATA_W'($urandom_range(0, 4095)), 31, 1'b0, 1'b0);
		drain();
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 4095)));
		run_phase(1023, CFG_DATA_W'($urandom_range(0, 4095)),
			CFG_DATA_W'($urandom_range(0, 4095)), 31, 1'b0, 1'b0);
		drain();

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
